### rtl/tgc_pkg.sv
`timescale 1ns / 1ps

package tgc_pkg;

  // Window geometry and coordinate width; the port widths are fixed to these.
  localparam int WINDOW_DEPTH      = 30;
  localparam int IDX_W             = 5;
  localparam int CNT_W             = 5;
  localparam int COORD_W           = 12;
  localparam int ZIGZAG_MIN_POINTS = 15;

  // Iterative square root: radicand and root widths.
  localparam int SQ_IN_W  = 34;
  localparam int SQ_OUT_W = 17;
  localparam int SQ_STEPS = 17;

  // Iterative divider by the point count.
  localparam int DIV_W   = 40;
  localparam int DIVR_W  = 5;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [2:0] {
    G_NONE       = 3'd0,
    G_CIRCLE     = 3'd1,
    G_ZIGZAG     = 3'd2,
    G_VERTICAL   = 3'd3,
    G_HORIZONTAL = 3'd4
  } gesture_t;

  typedef enum logic [2:0] {
    CFG_MIN_POINTS         = 3'd0,
    CFG_MIN_PATH_LENGTH    = 3'd1,
    CFG_CIRCLE_CLOSE_DIST  = 3'd2,
    CFG_CIRCLE_MIN_RADIUS  = 3'd3,
    CFG_ZIGZAG_MIN_STEP    = 3'd4,
    CFG_ZIGZAG_MIN_CHANGES = 3'd5,
    CFG_LINE_MIN_EXTENT    = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_A_RD,
    ST_A_USE,
    ST_A_SQ,
    ST_A_WAIT,
    ST_GATE,
    ST_CLOSE,
    ST_CX_GO,
    ST_CX_WAIT,
    ST_CY_GO,
    ST_CY_WAIT,
    ST_B_RD,
    ST_B_USE,
    ST_B_SQ,
    ST_B_WAIT,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_C_RD,
    ST_C_USE,
    ST_C_ACC,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_CIRC,
    ST_ZL,
    ST_FIN
  } tgc_state_t;

  // Handshake of the shared arithmetic units toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

### rtl/tgc_sqrt.sv
`timescale 1ns / 1ps

module tgc_sqrt
  import tgc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  radicand,
  output unit_status_t        status,
  output logic [SQ_OUT_W-1:0] root
);

  logic [SQ_IN_W-1:0] rem;
  logic [SQ_IN_W-1:0] acc;
  logic [SQ_IN_W-1:0] bitv;
  logic [4:0]         steps;
  logic               busy;
  logic               done;
  logic [SQ_IN_W:0]   trial;

  // One result bit per cycle, digit by digit from the top.
  assign trial = {1'b0, acc} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= radicand;
      acc   <= '0;
      bitv  <= SQ_IN_W'(1) << (SQ_IN_W - 2);
      steps <= 5'(SQ_STEPS);
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[SQ_IN_W-1:0];
        acc <= (acc >> 1) + bitv;
      end else begin
        acc <= acc >> 1;
      end
      bitv  <= bitv >> 2;
      steps <= steps - 5'd1;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign root        = acc[SQ_OUT_W-1:0];

endmodule

### rtl/tgc_div.sv
`timescale 1ns / 1ps

module tgc_div
  import tgc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output unit_status_t      status,
  output logic [DIV_W-1:0]  quotient
);

  logic [DIV_W-1:0]     q;
  logic [DIVR_W-1:0]    rem;
  logic [DIVR_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] steps;
  logic                 busy;
  logic                 done;
  logic [DIVR_W:0]      trial;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, q[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dividend;
      rem   <= '0;
      dvs   <= divisor;
      steps <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= DIVR_W'(trial - {1'b0, dvs});
        q   <= {q[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIVR_W-1:0];
        q   <= {q[DIV_W-2:0], 1'b0};
      end
      steps <= steps - DIV_CNT_W'(1);
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = q;

endmodule

### rtl/trajectory_gesture_classifier_unit.sv
`timescale 1ns / 1ps

// Trajectory gesture classifier. Each add beat pushes one point into a window
// of the latest 30 points held in a window memory, then walks the window to
// classify it as a circle, a zigzag, a vertical or a horizontal line.
// A hit empties the window; a clear beat empties it without a test. The block
// works on one item at a time: an add beat runs a path-length pass, which runs
// one bit-serial square root per segment; when the ends close up for a circle,
// a second pass computes radii (again through the square root unit and kept in
// a small radius memory), a third pass forms the variance, and four divisions
// by the point count are made. The result sits in an output register, so the
// next beat is accepted while a result still waits to be taken. Configuration
// is written through a plain write port; the user must write it only while the
// block is idle, which the block itself does not enforce.

module trajectory_gesture_classifier_unit
  import tgc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [COORD_W-1:0]  point_x,
  input  logic [COORD_W-1:0]  point_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          gesture,
  output logic [CNT_W-1:0]    points_held
);

  // Configuration registers.
  logic [4:0]  min_points;
  logic [15:0] min_path_length;
  logic [11:0] circle_close_dist;
  logic [11:0] circle_min_radius;
  logic [11:0] zigzag_min_step;
  logic [4:0]  zigzag_min_changes;
  logic [11:0] line_min_extent;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_points         <= 5'd20;
      min_path_length    <= 16'd100;
      circle_close_dist  <= 12'd50;
      circle_min_radius  <= 12'd30;
      zigzag_min_step    <= 12'd20;
      zigzag_min_changes <= 5'd3;
      line_min_extent    <= 12'd150;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MIN_POINTS:         min_points         <= cfg_data[4:0];
        CFG_MIN_PATH_LENGTH:    min_path_length    <= cfg_data;
        CFG_CIRCLE_CLOSE_DIST:  circle_close_dist  <= cfg_data[11:0];
        CFG_CIRCLE_MIN_RADIUS:  circle_min_radius  <= cfg_data[11:0];
        CFG_ZIGZAG_MIN_STEP:    zigzag_min_step    <= cfg_data[11:0];
        CFG_ZIGZAG_MIN_CHANGES: zigzag_min_changes <= cfg_data[4:0];
        CFG_LINE_MIN_EXTENT:    line_min_extent    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  tgc_state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] idx;
  logic             accept;
  logic             is_last;
  logic             out_load;

  // Window memory: x in the low half of a word, y in the high half.
  logic [2*COORD_W-1:0] win_mem [WINDOW_DEPTH];
  logic [2*COORD_W-1:0] win_rd;
  logic [SQ_OUT_W-1:0]  rad_mem [WINDOW_DEPTH];
  logic [SQ_OUT_W-1:0]  rad_rd;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(WINDOW_DEPTH)) begin
      s = s - (IDX_W+1)'(WINDOW_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_slot;
  logic             win_full;

  assign win_full = (count == CNT_W'(WINDOW_DEPTH));
  assign rd_addr  = wrap_add(head, idx);
  assign wr_slot  = win_full ? head : wrap_add(head, count);
  assign accept   = in_valid && !in_stall;
  assign is_last  = (idx == count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (accept && !req_type) begin
      win_mem[wr_slot] <= {point_y, point_x};
    end
    win_rd <= win_mem[rd_addr];
  end

  // Datapath registers.
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [COORD_W-1:0] prev_x, prev_y;
  logic [COORD_W-1:0] first_x, first_y;
  logic [COORD_W-1:0] last_x, last_y;
  logic [16:0]        sum_x, sum_y;
  logic [22:0]        path;
  logic               last_pos, last_neg;
  logic [4:0]         changes;
  logic [31:0]        sqa, sqb;
  logic [23:0]        cdsq;
  logic [15:0]        cx, cy;
  logic [21:0]        rsum;
  logic [SQ_OUT_W-1:0] avg;
  logic [33:0]        dsq;
  logic [38:0]        vsum;
  logic [33:0]        variance;
  logic [33:0]        avgsq;
  gesture_t           res;
  gesture_t           gesture_r;
  logic [CNT_W-1:0]   held_r;
  logic               out_valid_r;

  assign cur_x = win_rd[COORD_W-1:0];
  assign cur_y = win_rd[2*COORD_W-1:COORD_W];

  // Step to the previous point.
  logic               d_pos, d_neg, dy_neg;
  logic [COORD_W-1:0] dxm, dym;
  assign d_pos  = cur_x > prev_x;
  assign d_neg  = cur_x < prev_x;
  assign dy_neg = cur_y < prev_y;
  assign dxm    = d_neg ? prev_x - cur_x : cur_x - prev_x;
  assign dym    = dy_neg ? prev_y - cur_y : cur_y - prev_y;

  // End to end extents.
  logic [COORD_W-1:0] adx, ady;
  logic [COORD_W+1:0] adx3, ady3;
  assign adx  = (last_x < first_x) ? first_x - last_x : last_x - first_x;
  assign ady  = (last_y < first_y) ? first_y - last_y : last_y - first_y;
  assign adx3 = {1'b0, adx, 1'b0} + {2'b0, adx};
  assign ady3 = {1'b0, ady, 1'b0} + {2'b0, ady};

  // Q.4 offsets from the centroid.
  logic [15:0] x16, y16, exm, eym;
  assign x16 = {cur_x, 4'b0};
  assign y16 = {cur_y, 4'b0};
  assign exm = (x16 < cx) ? cx - x16 : x16 - cx;
  assign eym = (y16 < cy) ? cy - y16 : y16 - cy;

  logic [SQ_OUT_W-1:0] dev;
  assign dev = (rad_rd > avg) ? rad_rd - avg : avg - rad_rd;

  logic [32:0] sq_sum;
  assign sq_sum = {1'b0, sqa} + {1'b0, sqb};

  logic [37:0] var10, avg3;
  assign var10 = {1'b0, variance, 3'b0} + {3'b0, variance, 1'b0};
  assign avg3  = {3'b0, avgsq, 1'b0} + {4'b0, avgsq};

  logic zz_hit;
  assign zz_hit = (count >= CNT_W'(ZIGZAG_MIN_POINTS)) && (changes >= zigzag_min_changes);

  // Shared arithmetic units.
  logic                sq_start;
  logic [SQ_IN_W-1:0]  sq_in;
  unit_status_t        sq_st;
  logic [SQ_OUT_W-1:0] sq_root;
  logic                div_start;
  logic [DIV_W-1:0]    div_in;
  unit_status_t        div_st;
  logic [DIV_W-1:0]    div_q;

  tgc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .status   (sq_st),
    .root     (sq_root)
  );

  tgc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (count),
    .status   (div_st),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (state == ST_B_WAIT && sq_st.done) begin
      rad_mem[idx] <= sq_root;
    end
    rad_rd <= rad_mem[idx];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept) state_next = req_type ? ST_FIN : ST_CHECK;
      ST_CHECK:    state_next = (count == '0 || count < min_points) ? ST_FIN : ST_A_RD;
      ST_A_RD:     state_next = ST_A_USE;
      ST_A_USE: begin
        if (idx != '0) state_next = ST_A_SQ;
        else state_next = is_last ? ST_GATE : ST_A_RD;
      end
      ST_A_SQ:     state_next = ST_A_WAIT;
      ST_A_WAIT:   if (sq_st.done) state_next = is_last ? ST_GATE : ST_A_RD;
      ST_GATE:     state_next = (path < {3'b0, min_path_length, 4'b0}) ? ST_FIN : ST_CLOSE;
      ST_CLOSE:    state_next = (sq_sum > {9'b0, cdsq}) ? ST_ZL : ST_CX_GO;
      ST_CX_GO:    state_next = ST_CX_WAIT;
      ST_CX_WAIT:  if (div_st.done) state_next = ST_CY_GO;
      ST_CY_GO:    state_next = ST_CY_WAIT;
      ST_CY_WAIT:  if (div_st.done) state_next = ST_B_RD;
      ST_B_RD:     state_next = ST_B_USE;
      ST_B_USE:    state_next = ST_B_SQ;
      ST_B_SQ:     state_next = ST_B_WAIT;
      ST_B_WAIT:   if (sq_st.done) state_next = is_last ? ST_AVG_GO : ST_B_RD;
      ST_AVG_GO:   state_next = ST_AVG_WAIT;
      ST_AVG_WAIT: if (div_st.done) state_next = ST_C_RD;
      ST_C_RD:     state_next = ST_C_USE;
      ST_C_USE:    state_next = ST_C_ACC;
      ST_C_ACC:    state_next = is_last ? ST_VAR_GO : ST_C_RD;
      ST_VAR_GO:   state_next = ST_VAR_WAIT;
      ST_VAR_WAIT: if (div_st.done) state_next = ST_CIRC;
      ST_CIRC: begin
        if (var10 < avg3 && {4'b0, avg} > {5'b0, circle_min_radius, 4'b0}) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_ZL;
        end
      end
      ST_ZL:       state_next = ST_FIN;
      ST_FIN:      if (!out_valid_r || !out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    sq_start  = 1'b0;
    sq_in     = '0;
    div_start = 1'b0;
    div_in    = '0;
    out_load  = 1'b0;
    unique case (state)
      ST_A_SQ: begin
        sq_start = 1'b1;
        sq_in    = {sq_sum[25:0], 8'b0};
      end
      ST_B_SQ: begin
        sq_start = 1'b1;
        sq_in    = {1'b0, sq_sum};
      end
      ST_CX_GO: begin
        div_start = 1'b1;
        div_in    = {19'b0, sum_x, 4'b0};
      end
      ST_CY_GO: begin
        div_start = 1'b1;
        div_in    = {19'b0, sum_y, 4'b0};
      end
      ST_AVG_GO: begin
        div_start = 1'b1;
        div_in    = {18'b0, rsum};
      end
      ST_VAR_GO: begin
        div_start = 1'b1;
        div_in    = {1'b0, vsum};
      end
      ST_FIN:    out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      head        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        if (req_type) begin
          count <= '0;
          head  <= '0;
        end else if (win_full) begin
          head <= wrap_add(head, IDX_W'(1));
        end else begin
          count <= count + CNT_W'(1);
        end
      end else if (out_load && res != G_NONE) begin
        count <= '0;
        head  <= '0;
      end
    end
  end

  // Payload of the passes.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx      <= '0;
        sum_x    <= '0;
        sum_y    <= '0;
        path     <= '0;
        changes  <= '0;
        last_pos <= 1'b0;
        last_neg <= 1'b0;
        res      <= G_NONE;
      end
      ST_A_USE: begin
        sum_x  <= sum_x + 17'(cur_x);
        sum_y  <= sum_y + 17'(cur_y);
        prev_x <= cur_x;
        prev_y <= cur_y;
        last_x <= cur_x;
        last_y <= cur_y;
        sqa    <= 32'(dxm * dxm);
        sqb    <= 32'(dym * dym);
        if (idx == '0) begin
          first_x <= cur_x;
          first_y <= cur_y;
          idx     <= idx + IDX_W'(1);
        end
        // Direction changes count from the second step on.
        if (idx >= IDX_W'(2)) begin
          if (((last_neg && d_pos) || (last_pos && d_neg)) && dxm > zigzag_min_step) begin
            changes <= changes + 5'd1;
          end
          if (d_pos || d_neg) begin
            last_pos <= d_pos;
            last_neg <= d_neg;
          end
        end
      end
      ST_A_WAIT: begin
        if (sq_st.done) begin
          path <= path + 23'(sq_root);
          idx  <= idx + IDX_W'(1);
        end
      end
      ST_GATE: begin
        sqa  <= 32'(adx * adx);
        sqb  <= 32'(ady * ady);
        cdsq <= circle_close_dist * circle_close_dist;
      end
      ST_CX_WAIT: if (div_st.done) cx <= div_q[15:0];
      ST_CY_WAIT: begin
        if (div_st.done) begin
          cy   <= div_q[15:0];
          idx  <= '0;
          rsum <= '0;
        end
      end
      ST_B_USE: begin
        sqa <= exm * exm;
        sqb <= eym * eym;
      end
      ST_B_WAIT: begin
        if (sq_st.done) begin
          rsum <= rsum + 22'(sq_root);
          idx  <= idx + IDX_W'(1);
        end
      end
      ST_AVG_WAIT: begin
        if (div_st.done) begin
          avg  <= div_q[SQ_OUT_W-1:0];
          idx  <= '0;
          vsum <= '0;
        end
      end
      ST_C_USE: dsq <= dev * dev;
      ST_C_ACC: begin
        vsum <= vsum + 39'(dsq);
        idx  <= idx + IDX_W'(1);
      end
      ST_VAR_WAIT: begin
        if (div_st.done) begin
          variance <= div_q[33:0];
          avgsq    <= avg * avg;
        end
      end
      ST_CIRC: res <= G_CIRCLE;
      ST_ZL: begin
        priority if (zz_hit) begin
          res <= G_ZIGZAG;
        end else if ({2'b0, ady} > adx3 && ady > line_min_extent) begin
          res <= G_VERTICAL;
        end else if ({2'b0, adx} > ady3 && adx > line_min_extent) begin
          res <= G_HORIZONTAL;
        end else begin
          res <= G_NONE;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          gesture_r <= res;
          held_r    <= (res != G_NONE) ? '0 : count;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign gesture     = gesture_r;
  assign points_held = held_r;

  // The window never holds more points than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW_DEPTH))
    else $error("window count beyond depth");

  // A result appears only from the final state of an item.
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result without finished item");

  // A clear beat empties the window at once.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type) |=> (count == '0))
    else $error("clear beat left points in window");

  // A recognized gesture always reports an empty window.
  a_hit_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gesture != G_NONE) |-> (points_held == '0))
    else $error("gesture with points still held");

endmodule
